### sv/dlt_pkg.sv
package dlt_pkg;

  localparam int unsigned CfgWidth      = 20;
  localparam int unsigned ReportBytesW  = 48;
  localparam logic [CfgWidth-1:0] IntervalReset = 20'd1000;

  typedef enum logic [1:0] {
    STATUS_IGNORED  = 2'd0,
    STATUS_COUNTED  = 2'd1,
    STATUS_INTERVAL = 2'd2,
    STATUS_FINAL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] seq_id;
    logic [15:0] byte_count;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    status_e                  status;
    logic [7:0]               session_number;
    logic [ReportBytesW-1:0]  report_bytes;
    logic [31:0]              report_datagrams;
    logic [31:0]              report_dropped;
    logic [31:0]              report_out_of_order;
    logic [31:0]              elapsed_ms;
  } result_t;

endpackage

### sv/datagram_sequence_loss_tracker.sv
// Datagram sequence loss tracker: takes one datagram header per cycle
// unless stalled (sequence id, byte length, millisecond time) and returns
// one result per datagram in order, giving status, session number and
// interval or final session reports of bytes, datagrams, gap-inferred drops
// and, in final reports, out-of-order count. Ids 0 or 1 open a session when
// idle, a negative id closes it. A datagram is held in the input register,
// and its result is registered in the result buffer before it is shown;
// sustained rate is one datagram per cycle while the output does not stall.
// A two-entry result buffer lets inputs keep flowing while one result waits;
// inputs stall only once both entries are held. The user must write the
// report interval register through the configuration port only while no
// datagram is in flight, not enforced by the block. It resets to 1000 ms.
module datagram_sequence_loss_tracker #(
  parameter int unsigned BYTE_COUNT_WIDTH = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dlt_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  seq_id_i,
  input  logic [15:0]                  byte_count_i,
  input  logic [31:0]                  now_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [7:0]                   session_number_o,
  output logic [dlt_pkg::ReportBytesW-1:0] report_bytes_o,
  output logic [31:0]                  report_datagrams_o,
  output logic [31:0]                  report_dropped_o,
  output logic [31:0]                  report_out_of_order_o,
  output logic [31:0]                  elapsed_ms_o
);
  import dlt_pkg::*;

  logic [CfgWidth-1:0] interval_q;
  logic                in_valid_q;
  item_t               item_q;
  logic                in_accept;
  logic                push;
  logic                buf_full;
  result_t             result;
  result_t             out_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      interval_q <= cfg_data_i;
    end
  end

  // input register
  assign in_stall_o = in_valid_q && buf_full;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign push       = in_valid_q && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept || (in_valid_q && !push);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.seq_id     <= seq_id_i;
      item_q.byte_count <= byte_count_i;
      item_q.now_ms     <= now_ms_i;
    end
  end

  dlt_core #(
    .BYTE_COUNT_WIDTH(BYTE_COUNT_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (push),
    .item_i    (item_q),
    .interval_i(interval_q),
    .result_o  (result)
  );

  dlt_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     (result),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign status_o              = out_data.status;
  assign session_number_o      = out_data.session_number;
  assign report_bytes_o        = out_data.report_bytes;
  assign report_datagrams_o    = out_data.report_datagrams;
  assign report_dropped_o      = out_data.report_dropped;
  assign report_out_of_order_o = out_data.report_out_of_order;
  assign elapsed_ms_o          = out_data.elapsed_ms;

endmodule

### sv/dlt_core.sv
module dlt_core #(
  parameter int unsigned BYTE_COUNT_WIDTH = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  dlt_pkg::item_t                  item_i,
  input  logic [dlt_pkg::CfgWidth-1:0]    interval_i,
  output dlt_pkg::result_t                result_o
);
  import dlt_pkg::*;

  localparam int unsigned BW = BYTE_COUNT_WIDTH;

  logic          active_q, active_d;
  logic [7:0]    session_q, session_d;
  logic [31:0]   start_time_q, start_time_d;
  logic [31:0]   last_seen_q, last_seen_d;
  logic [31:0]   expected_q, expected_d;
  logic [BW-1:0] tot_bytes_q, tot_bytes_d;
  logic [31:0]   tot_dgrams_q, tot_dgrams_d;
  logic [31:0]   tot_dropped_q, tot_dropped_d;
  logic [31:0]   tot_reord_q, tot_reord_d;
  logic          int_run_q, int_run_d;
  logic [31:0]   int_start_q, int_start_d;
  logic [BW-1:0] int_bytes_q, int_bytes_d;
  logic [31:0]   int_dgrams_q, int_dgrams_d;
  logic [31:0]   int_dropped_q, int_dropped_d;

  logic          open_sess;
  logic          seq_neg;
  logic [31:0]   gap;
  logic [31:0]   diff;
  logic [BW-1:0] len_ext;

  assign seq_neg   = item_i.seq_id[31];
  assign open_sess = !active_q && (item_i.seq_id == 32'd0 || item_i.seq_id == 32'd1);
  assign len_ext   = BW'(item_i.byte_count);

  always_comb begin
    active_d      = active_q;
    session_d     = session_q;
    start_time_d  = start_time_q;
    last_seen_d   = last_seen_q;
    expected_d    = expected_q;
    tot_bytes_d   = tot_bytes_q;
    tot_dgrams_d  = tot_dgrams_q;
    tot_dropped_d = tot_dropped_q;
    tot_reord_d   = tot_reord_q;
    int_run_d     = int_run_q;
    int_start_d   = int_start_q;
    int_bytes_d   = int_bytes_q;
    int_dgrams_d  = int_dgrams_q;
    int_dropped_d = int_dropped_q;
    gap           = '0;
    diff          = '0;

    result_o                = '0;
    result_o.status         = STATUS_IGNORED;
    result_o.session_number = session_q;

    // session open clears the counters and expected id before the item is counted
    if (open_sess) begin
      active_d      = 1'b1;
      session_d     = session_q + 8'd1;
      start_time_d  = item_i.now_ms;
      expected_d    = '0;
      tot_bytes_d   = '0;
      tot_dgrams_d  = '0;
      tot_dropped_d = '0;
      tot_reord_d   = '0;
      int_run_d     = 1'b0;
      int_start_d   = '0;
      int_bytes_d   = '0;
      int_dgrams_d  = '0;
      int_dropped_d = '0;
    end

    if (active_q && seq_neg) begin
      active_d                     = 1'b0;
      result_o.status              = STATUS_FINAL;
      result_o.report_bytes        = ReportBytesW'(tot_bytes_q);
      result_o.report_datagrams    = tot_dgrams_q;
      result_o.report_dropped      = tot_dropped_q;
      result_o.report_out_of_order = tot_reord_q;
      result_o.elapsed_ms          = (last_seen_q > start_time_q) ?
                                     last_seen_q - start_time_q : 32'd0;
    end else if (active_q || open_sess) begin
      result_o.session_number = session_d;
      result_o.status         = STATUS_COUNTED;
      if ($signed(expected_d) < $signed(item_i.seq_id)) begin
        gap           = item_i.seq_id - expected_d;
        tot_dropped_d = tot_dropped_d + gap;
        expected_d    = item_i.seq_id + 32'd1;
      end else if ($signed(expected_d) > $signed(item_i.seq_id)) begin
        tot_reord_d = tot_reord_d + 32'd1;
      end else begin
        expected_d = expected_d + 32'd1;
      end
      tot_dgrams_d = tot_dgrams_d + 32'd1;
      tot_bytes_d  = tot_bytes_d + len_ext;

      if (interval_i != '0) begin
        last_seen_d   = item_i.now_ms;
        int_dgrams_d  = int_dgrams_d + 32'd1;
        int_dropped_d = int_dropped_d + gap;
        int_bytes_d   = int_bytes_d + len_ext;
        if (int_run_d) begin
          diff = item_i.now_ms - int_start_d;
          if (diff >= 32'(interval_i)) begin
            result_o.status           = STATUS_INTERVAL;
            result_o.report_bytes     = ReportBytesW'(int_bytes_d);
            result_o.report_datagrams = int_dgrams_d;
            result_o.report_dropped   = int_dropped_d;
            result_o.elapsed_ms       = diff;
            int_run_d     = 1'b0;
            int_start_d   = '0;
            int_bytes_d   = '0;
            int_dgrams_d  = '0;
            int_dropped_d = '0;
          end
        end else begin
          int_run_d   = 1'b1;
          int_start_d = item_i.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      session_q     <= '0;
      start_time_q  <= '0;
      last_seen_q   <= '0;
      expected_q    <= '0;
      tot_bytes_q   <= '0;
      tot_dgrams_q  <= '0;
      tot_dropped_q <= '0;
      tot_reord_q   <= '0;
      int_run_q     <= 1'b0;
      int_start_q   <= '0;
      int_bytes_q   <= '0;
      int_dgrams_q  <= '0;
      int_dropped_q <= '0;
    end else if (step_i) begin
      active_q      <= active_d;
      session_q     <= session_d;
      start_time_q  <= start_time_d;
      last_seen_q   <= last_seen_d;
      expected_q    <= expected_d;
      tot_bytes_q   <= tot_bytes_d;
      tot_dgrams_q  <= tot_dgrams_d;
      tot_dropped_q <= tot_dropped_d;
      tot_reord_q   <= tot_reord_d;
      int_run_q     <= int_run_d;
      int_start_q   <= int_start_d;
      int_bytes_q   <= int_bytes_d;
      int_dgrams_q  <= int_dgrams_d;
      int_dropped_q <= int_dropped_d;
    end
  end

  a_open_bumps_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && open_sess |=> active_q && session_q == $past(session_q) + 8'd1)
    else $error("session open did not advance the session number");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.status == STATUS_FINAL |=> !active_q)
    else $error("final report left the session open");

  a_ignored_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.status == STATUS_IGNORED |=>
      !active_q && $stable(session_q) && $stable(tot_dgrams_q))
    else $error("ignored datagram changed session state");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && active_q && result_o.status == STATUS_COUNTED |=>
      tot_dgrams_q == $past(tot_dgrams_q) + 32'd1)
    else $error("counted datagram not added to total");

  a_interval_needs_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && result_o.status == STATUS_INTERVAL |-> interval_i != '0 && int_run_q)
    else $error("interval report without a running interval");

endmodule

### sv/dlt_out_buf.sv
module dlt_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dlt_pkg::result_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dlt_pkg::result_t out_data_o
);
  import dlt_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q;
  result_t skid_data_q;
  logic    pop;
  logic    out_load;
  logic    skid_load;

  assign pop       = out_valid_q && !out_stall_i;
  assign out_load  = !out_valid_q || pop;
  assign skid_load = push_i && out_valid_q && !pop;

  assign out_valid_d  = skid_valid_q || push_i || (out_valid_q && !pop);
  assign skid_valid_d = skid_load || (skid_valid_q && !pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end
    if (skid_load) begin
      skid_data_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("transfer pushed into a full buffer");

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && pop |=> out_valid_q)
    else $error("skid entry lost on pop");

endmodule
